@@ sv/assert_macros.svh @@
// Assertion macros used by the conditioner RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every clock edge outside reset.
`define AIC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition implies a property in the following cycle.
`define AIC_ASSERT_NEXT(lbl, clk, rst, cond, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

@@ sv/adc_cond_pkg.sv @@
// Types and constants of the ADC input conditioner.
package adc_cond_pkg;

   localparam int ADC_W    = 12;
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 15;
   localparam int LEVEL_W  = 15;
   localparam int SCALE_SH = 4;   // scale by 16

   // Register indexes of the control port.
   typedef enum logic [0:0] {
      CSR_DC_BLOCK_COEF = 1'b0,
      CSR_LEVEL_RATE    = 1'b1
   } csr_index_type;

   localparam logic [COEF_W-1:0]  COEF_RESET = 15'd32700;
   localparam logic [COEF_W-1:0]  RATE_RESET = 15'd10;
   localparam logic [COEF_W-1:0]  Q15_MAX    = 15'h7FFF;
   localparam logic [LEVEL_W-1:0] MAG_MAX    = 15'h7FFF;
   localparam logic [LEVEL_W-1:0] CLIP_MAG   = 15'h7FFF - 15'd3;

   localparam logic signed [SAMPLE_W-1:0] S16_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] S16_MIN = -16'sh8000;
   localparam logic signed [SAMPLE_W-1:0] CLIP_POS = 16'sd32764;
   localparam logic signed [SAMPLE_W-1:0] CLIP_NEG = -16'sd32764;

endpackage

@@ sv/adc_input_conditioner.sv @@
// ADC input conditioner: oversampling sum, DC-blocking filter, clip flag, envelope.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/ready    | req_adc_raw
//  rsp     | out       | rsp_valid/ready    | rsp_sample_out, rsp_near_clip, rsp_level
//  csr     | in        | csr_wr_en          | csr_index, csr_wdata
//
// One word is accepted per cycle while req_ready is high. The word that completes a group
// of OVERSAMPLE passes through a sum stage, a filter stage (one 16x16 multiply in the
// filter feedback) and the output register (envelope update) before its result shows.
// Reset is synchronous, sets the control registers to defaults and clears the filter state.
// A stalled output holds; two more groups can be buffered in the stages behind it.
`include "assert_macros.svh"

module adc_input_conditioner #(
   parameter int OVERSAMPLE       = 4,
   parameter int OVERSAMPLE_SHIFT = 2
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [adc_cond_pkg::ADC_W-1:0]          req_adc_raw,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [adc_cond_pkg::SAMPLE_W-1:0] rsp_sample_out,
   output logic                                    rsp_near_clip,
   output logic [adc_cond_pkg::LEVEL_W-1:0]        rsp_level,
   input  logic                                    csr_wr_en,
   input  adc_cond_pkg::csr_index_type             csr_index,
   input  logic [adc_cond_pkg::COEF_W-1:0]         csr_wdata
);
   import adc_cond_pkg::*;

   localparam int CNT_W = (OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 1;
   localparam int SUM_W = ADC_W + ((OVERSAMPLE > 1) ? $clog2(OVERSAMPLE) : 0);
   localparam int SCL_W = SUM_W + SCALE_SH;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(OVERSAMPLE - 1);
   localparam logic signed [SCL_W-1:0] SCL_HI = $signed(SCL_W'(32767));
   localparam logic signed [SCL_W-1:0] SCL_LO = $signed(SCL_W'(-32768));

   // Control registers.
   logic [COEF_W-1:0] coef_ff, rate_ff;

   // Group accumulator.
   logic signed [SUM_W-1:0] sum_ff, sum_in, sum_add;
   logic [CNT_W-1:0]        count_ff, count_in;

   // Sum stage.
   logic                       xs_valid_ff, xs_valid_in;
   logic signed [SAMPLE_W-1:0] xs_x_ff, x_in;
   logic signed [SUM_W-1:0]    shifted;
   logic signed [SCL_W-1:0]    scaled;

   // Filter stage; prev_out_ff doubles as the stage payload.
   logic                       ys_valid_ff, ys_valid_in;
   logic signed [SAMPLE_W-1:0] prev_in_ff, prev_out_ff, y_in;
   logic [LEVEL_W-1:0]         ys_mag_ff, mag_in;
   logic signed [31:0]         fb_prod;
   logic signed [16:0]         fb;
   logic signed [17:0]         acc;

   // Output register; envelope_ff is the level field.
   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_W-1:0] rsp_sample_ff;
   logic                       rsp_clip_ff;
   logic [LEVEL_W-1:0]         envelope_ff, envelope_in;
   logic [29:0]                p_new, p_old;
   logic [LEVEL_W:0]           lvl_sum;

   // Pipeline flow.
   logic out_free, ys_to_out, ys_free, xs_to_ys, accept, group_done;

   // Clip flag agrees with the sample it goes out with.
   logic clip_ok;

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign ys_to_out  = ys_valid_ff && out_free;
   assign ys_free    = !ys_valid_ff || ys_to_out;
   assign xs_to_ys   = xs_valid_ff && ys_free;
   assign req_ready  = !xs_valid_ff || xs_to_ys;
   assign accept     = req_valid && req_ready;
   assign group_done = accept && (count_ff == CNT_LAST);

   // Offset the raw word to signed and add it into the group.
   always_comb begin
      sum_add = sum_ff + SUM_W'($signed({~req_adc_raw[ADC_W-1], req_adc_raw[ADC_W-2:0]}));
      shifted = sum_add >>> OVERSAMPLE_SHIFT;
      scaled  = SCL_W'(shifted) <<< SCALE_SH;
      if (scaled > SCL_HI) begin
         x_in = S16_MAX;
      end else if (scaled < SCL_LO) begin
         x_in = S16_MIN;
      end else begin
         x_in = scaled[SAMPLE_W-1:0];
      end
      if (!accept) begin
         sum_in   = sum_ff;
         count_in = count_ff;
      end else if (group_done) begin
         sum_in   = '0;
         count_in = '0;
      end else begin
         sum_in   = sum_add;
         count_in = count_ff + CNT_W'(1);
      end
   end

   // High-pass: y = x - x1 + floor(y1 * coef / 2^15), saturated.
   always_comb begin
      fb_prod = 32'(prev_out_ff) * 32'($signed({1'b0, coef_ff}));
      fb      = $signed(fb_prod[31:15]);
      acc     = 18'(xs_x_ff) - 18'(prev_in_ff) + 18'(fb);
      if (acc > 18'sd32767) begin
         y_in = S16_MAX;
      end else if (acc < -18'sd32768) begin
         y_in = S16_MIN;
      end else begin
         y_in = acc[SAMPLE_W-1:0];
      end
      // Magnitude, with the most negative value held at full scale.
      if (y_in == S16_MIN) begin
         mag_in = MAG_MAX;
      end else if (y_in < 0) begin
         mag_in = LEVEL_W'(-y_in);
      end else begin
         mag_in = LEVEL_W'(y_in);
      end
   end

   // Envelope: weighted mix of new magnitude and old envelope.
   always_comb begin
      p_new       = 30'(rate_ff) * 30'(ys_mag_ff);
      p_old       = 30'(Q15_MAX - rate_ff) * 30'(envelope_ff);
      lvl_sum     = {1'b0, p_new[29:15]} + {1'b0, p_old[29:15]};
      envelope_in = lvl_sum[LEVEL_W-1:0];
   end

   assign xs_valid_in  = group_done || (xs_valid_ff && !xs_to_ys);
   assign ys_valid_in  = xs_to_ys || (ys_valid_ff && !ys_to_out);
   assign rsp_valid_in = ys_to_out || (rsp_valid_ff && !rsp_ready);

   // Control registers, group accumulator, valid flags, filter state and envelope.
   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff      <= COEF_RESET;
         rate_ff      <= RATE_RESET;
         sum_ff       <= '0;
         count_ff     <= '0;
         xs_valid_ff  <= 1'b0;
         ys_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         prev_in_ff   <= '0;
         prev_out_ff  <= '0;
         envelope_ff  <= '0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_DC_BLOCK_COEF: coef_ff <= csr_wdata;
               CSR_LEVEL_RATE:    rate_ff <= csr_wdata;
               default: ;
            endcase
         end
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         xs_valid_ff  <= xs_valid_in;
         ys_valid_ff  <= ys_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (xs_to_ys) begin
            prev_in_ff  <= xs_x_ff;
            prev_out_ff <= y_in;
         end
         if (ys_to_out) begin
            envelope_ff <= envelope_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (group_done) begin
         xs_x_ff <= x_in;
      end
      if (xs_to_ys) begin
         ys_mag_ff <= mag_in;
      end
      if (ys_to_out) begin
         rsp_sample_ff <= prev_out_ff;
         rsp_clip_ff   <= (ys_mag_ff >= CLIP_MAG);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_ff;
   assign rsp_near_clip  = rsp_clip_ff;
   assign rsp_level      = envelope_ff;

   assign clip_ok = !rsp_valid ||
                    (rsp_near_clip == ((rsp_sample_out >= CLIP_POS) ||
                                       (rsp_sample_out <= CLIP_NEG)));

   // Checks.
   `AIC_ASSERT(a_count_range, clock, reset, count_ff <= CNT_LAST, "group count out of range")
   `AIC_ASSERT(a_clip_match, clock, reset, clip_ok, "near clip flag does not match sample")
   `AIC_ASSERT(a_level_max, clock, reset, rsp_level != MAG_MAX, "envelope reached full scale")
   `AIC_ASSERT_NEXT(a_env_hold, clock, reset, !ys_to_out, $stable(envelope_ff), "envelope moved")

endmodule
